### rtl/sis_pkg.sv
// Shared types and constants for the sorted insert stack.
// Used by sis_cell and sorted_insert_stack_top; no dependencies.
`default_nettype none

package sis_pkg;

  localparam int DEPTH        = 16;
  localparam int PAYLOAD_BITS = 32;
  localparam int KEY_W        = 32;
  localparam int PAY_PORT_W   = 32;
  localparam int CNT_W        = $clog2(DEPTH + 1);
  localparam int IDX_W        = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // command codes
  localparam logic [1:0] CMD_PUSH     = 2'd0;
  localparam logic [1:0] CMD_ORD_PUSH = 2'd1;
  localparam logic [1:0] CMD_POP      = 2'd2;

  // status codes
  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  // broadcast from the top level to every cell
  typedef struct packed {
    logic                      wr_en;    // accepted push with room left
    logic                      plain;    // plain push: insert at the top
    logic [CNT_W-1:0]          count;    // entries held before the transfer
    logic [IDX_W-1:0]          top_idx;  // index of the current top entry
    logic signed [KEY_W-1:0]   key;
    logic [PAYLOAD_BITS-1:0]   payload;
  } cell_ctl_t;

endpackage

`default_nettype wire

### rtl/sis_cell.sv
// One slot of the stack: holds a key and payload, compares against the new key,
// and shifts up from its lower neighbor on insert. Depends on sis_pkg.
`default_nettype none

module sis_cell (
  input  wire logic                                clk_i,
  input  wire logic [sis_pkg::IDX_W-1:0]           idx_i,
  input  wire sis_pkg::cell_ctl_t                  ctl_i,
  input  wire logic                                s_above_i,  // a smaller key sits above
  input  wire logic                                s_below_i,  // smaller key at or above lower cell
  input  wire logic signed [sis_pkg::KEY_W-1:0]    key_below_i,
  input  wire logic [sis_pkg::PAYLOAD_BITS-1:0]    pay_below_i,
  input  wire logic signed [sis_pkg::KEY_W-1:0]    top_key_i,
  input  wire logic [sis_pkg::PAYLOAD_BITS-1:0]    top_pay_i,
  output      logic                                s_o,
  output      logic signed [sis_pkg::KEY_W-1:0]    key_o,
  output      logic [sis_pkg::PAYLOAD_BITS-1:0]    pay_o,
  output      logic signed [sis_pkg::KEY_W-1:0]    top_key_o,
  output      logic [sis_pkg::PAYLOAD_BITS-1:0]    top_pay_o
);

  logic signed [sis_pkg::KEY_W-1:0]  key_q, key_d;
  logic [sis_pkg::PAYLOAD_BITS-1:0]  pay_q, pay_d;
  logic                              valid;
  logic                              lt;
  logic                              ins_here;
  logic                              is_top;

  assign valid = {1'b0, idx_i} < ctl_i.count;
  // plain push counts every held entry as smaller, so the slot lands on top
  assign lt    = valid && (ctl_i.plain || (key_q < ctl_i.key));
  assign s_o   = s_above_i | lt;

  // insertion slot is just above the topmost smaller entry
  assign ins_here = !s_o && s_below_i;

  always_comb begin
    key_d = key_q;
    pay_d = pay_q;
    if (ctl_i.wr_en && !s_o) begin
      if (ins_here) begin
        key_d = ctl_i.key;
        pay_d = ctl_i.payload;
      end else begin
        key_d = key_below_i;
        pay_d = pay_below_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    pay_q <= pay_d;
  end

  assign key_o = key_q;
  assign pay_o = pay_q;

  // OR the top entry into the read-out chain
  assign is_top    = (idx_i == ctl_i.top_idx);
  assign top_key_o = top_key_i | (is_top ? key_q : '0);
  assign top_pay_o = top_pay_i | (is_top ? pay_q : '0);

endmodule

`default_nettype wire

### rtl/sorted_insert_stack_top.sv
// Top level of the sorted insert stack: command decode, entry count, cell chain
// and output register. Depends on sis_pkg and sis_cell.
//
//  channel   dir  payload (tdata, low bit first)
//  s_axis    in   command[1:0], item_key[33:2], item_payload[65:34], zero pad to 72
//  m_axis    out  popped_key[31:0], popped_payload[63:32], status[65:64],
//                 entry_count[70:66], is_empty[71]
//
// One command per cycle; the result is registered and appears the cycle after the
// transfer. All cells compare in parallel and a top-down prefix chain picks the
// insertion slot in that same cycle. Reset clears the count and the output valid;
// cell contents are not reset. A stalled result holds the input off only while
// the output register is full and not being taken.
`default_nettype none

module sorted_insert_stack_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output      logic        s_axis_tready,
  input  wire logic [71:0] s_axis_tdata,   // command, item_key, item_payload
  output      logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output      logic [71:0] m_axis_tdata    // popped_key, popped_payload, status,
                                           // entry_count, is_empty
);

  localparam int D  = sis_pkg::DEPTH;
  localparam int CW = sis_pkg::CNT_W;
  localparam int KW = sis_pkg::KEY_W;
  localparam int PB = sis_pkg::PAYLOAD_BITS;
  localparam int PW = sis_pkg::PAY_PORT_W;

  logic                 in_xfer;
  logic [1:0]           cmd;
  logic signed [KW-1:0] in_key;
  logic [PB-1:0]        in_pay;
  logic                 full;
  logic                 empty_now;
  logic                 is_push;
  logic                 is_pop;
  logic                 do_push;
  logic                 do_pop;
  sis_pkg::cell_ctl_t   ctl;

  logic [CW-1:0]        count_q, count_d;
  logic                 out_valid_q;
  logic [71:0]          out_data_q, out_data_d;
  logic [1:0]           status;

  logic                 s_chain [D+1];
  logic signed [KW-1:0] key_chain [D+1];
  logic [PB-1:0]        pay_chain [D+1];
  logic signed [KW-1:0] topk_chain [D+1];
  logic [PB-1:0]        topp_chain [D+1];

  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = !out_valid_q || m_axis_tready;

  assign cmd    = s_axis_tdata[1:0];
  assign in_key = s_axis_tdata[33:2];
  assign in_pay = PB'(s_axis_tdata[65:34]);

  assign full      = (count_q == CW'(D));
  assign empty_now = (count_q == '0);
  assign is_push   = (cmd == sis_pkg::CMD_PUSH) || (cmd == sis_pkg::CMD_ORD_PUSH);
  assign is_pop    = (cmd == sis_pkg::CMD_POP);
  assign do_push   = in_xfer && is_push && !full;
  assign do_pop    = in_xfer && is_pop && !empty_now;

  always_comb begin
    ctl         = '0;
    ctl.wr_en   = do_push;
    ctl.plain   = (cmd == sis_pkg::CMD_PUSH);
    ctl.count   = count_q;
    ctl.top_idx = sis_pkg::IDX_W'(count_q - CW'(1));
    ctl.key     = in_key;
    ctl.payload = in_pay;
  end

  // chain ends: nothing above the top cell; the slot below cell 0 is always smaller
  assign s_chain[D]    = 1'b0;
  assign key_chain[0]  = in_key;
  assign pay_chain[0]  = in_pay;
  assign topk_chain[0] = '0;
  assign topp_chain[0] = '0;

  logic s_lo [D+1];
  assign s_lo[0] = 1'b1;

  for (genvar i = 0; i < D; i++) begin : g_cell
    logic s_out;
    if (i > 0) begin : g_lo
      assign s_lo[i] = s_chain[i-1];
    end
    sis_cell u_cell (
      .clk_i       (clk_i),
      .idx_i       (sis_pkg::IDX_W'(i)),
      .ctl_i       (ctl),
      .s_above_i   (s_chain[i+1]),
      .s_below_i   (s_lo[i]),
      .key_below_i (key_chain[i]),
      .pay_below_i (pay_chain[i]),
      .top_key_i   (topk_chain[i]),
      .top_pay_i   (topp_chain[i]),
      .s_o         (s_out),
      .key_o       (key_chain[i+1]),
      .pay_o       (pay_chain[i+1]),
      .top_key_o   (topk_chain[i+1]),
      .top_pay_o   (topp_chain[i+1])
    );
    assign s_chain[i] = s_out;
  end
  assign s_lo[D] = s_chain[D-1];

  always_comb begin
    count_d = count_q;
    if (do_push) begin
      count_d = count_q + CW'(1);
    end else if (do_pop) begin
      count_d = count_q - CW'(1);
    end
  end

  always_comb begin
    status = sis_pkg::ST_DONE;
    if (is_push && full) begin
      status = sis_pkg::ST_FULL;
    end else if (is_pop && empty_now) begin
      status = sis_pkg::ST_EMPTY;
    end
  end

  always_comb begin
    out_data_d        = '0;
    if (do_pop) begin
      out_data_d[31:0]  = topk_chain[D];
      out_data_d[63:32] = PW'(topp_chain[D]);
    end
    out_data_d[65:64] = status;
    out_data_d[70:66] = 5'(count_d);
    out_data_d[71]    = (count_d == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (in_xfer) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(D))
    else $error("entry count above depth");

  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && m_axis_tdata[65:64] == sis_pkg::ST_FULL)
      |-> (m_axis_tdata[70:66] == 5'(D)))
    else $error("full status with room left");

  a_empty_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (m_axis_tdata[71] == (m_axis_tdata[70:66] == 5'd0)))
    else $error("empty flag disagrees with count");

  a_pop_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_pop |=> (count_q == $past(count_q) - CW'(1)))
    else $error("pop did not decrement count");

  a_push_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_push |=> (count_q == $past(count_q) + CW'(1)))
    else $error("push did not increment count");

endmodule

`default_nettype wire

### test/sorted_insert_stack_top_test.sv
// Testbench for sorted_insert_stack_top: a directed table and then random commands,
// each result checked against a stack model here or a typed-in one. Depends on sis_pkg.
module sorted_insert_stack_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] CMD_NOP = 2'd3;  // unused code, leaves the stack alone
  localparam int RANDOM_ITEMS = 450;
  localparam int TAIL_CYCLES = 20;

  typedef struct {
    logic signed [sis_pkg::KEY_W-1:0] key;
    logic [31:0]                      payload;
    logic [1:0]                       status;
    logic [sis_pkg::CNT_W-1:0]        count;
    logic                             empty;
  } stack_result_t;

  typedef struct {
    logic [1:0]                       cmd;
    logic signed [sis_pkg::KEY_W-1:0] key;
    logic [31:0]                      payload;
    bit                               fixed;    // expectation typed in below
    stack_result_t                    result;
  } stack_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [71:0] s_axis_tdata;   // command, item_key, item_payload
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [71:0] m_axis_tdata;   // popped_key, popped_payload, status, entry_count, is_empty

  // stack contents as the block should hold them
  logic signed [sis_pkg::KEY_W-1:0]   stack_keys [sis_pkg::DEPTH];
  logic [sis_pkg::PAYLOAD_BITS-1:0]   stack_pays [sis_pkg::DEPTH];
  int                                 stack_fill;

  stack_result_t pending_results[$];
  stack_row_t    directed_rows[$];
  int            mismatch_count;

  sorted_insert_stack_top u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #200000;
    $display("FAIL sorted_insert_stack_top");
    $finish;
  end

  function automatic stack_result_t apply_command(logic [1:0] cmd,
                                                  logic signed [sis_pkg::KEY_W-1:0] key,
                                                  logic [31:0] payload);
    stack_result_t res;
    int slot;
    res.key = '0;
    res.payload = '0;
    res.status = sis_pkg::ST_DONE;
    if (cmd == sis_pkg::CMD_PUSH || cmd == sis_pkg::CMD_ORD_PUSH) begin
      if (stack_fill >= sis_pkg::DEPTH) begin
        res.status = sis_pkg::ST_FULL;
      end else begin
        slot = 0;
        if (cmd == sis_pkg::CMD_PUSH) begin
          slot = stack_fill;
        end else begin
          // scan down from the top for the first smaller key
          for (int i = stack_fill; i > 0; i--) begin
            if (stack_keys[i-1] < key) begin
              slot = i;
              break;
            end
          end
        end
        for (int i = stack_fill; i > slot; i--) begin
          stack_keys[i] = stack_keys[i-1];
          stack_pays[i] = stack_pays[i-1];
        end
        stack_keys[slot] = key;
        stack_pays[slot] = payload[sis_pkg::PAYLOAD_BITS-1:0];
        stack_fill++;
      end
    end else if (cmd == sis_pkg::CMD_POP) begin
      if (stack_fill == 0) begin
        res.status = sis_pkg::ST_EMPTY;
      end else begin
        stack_fill--;
        res.key = stack_keys[stack_fill];
        res.payload = 32'(stack_pays[stack_fill]);
      end
    end
    res.count = sis_pkg::CNT_W'(stack_fill);
    res.empty = (stack_fill == 0);
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h, want %h at %0t", what, got, want, $realtime);
    mismatch_count++;
  endtask

  task automatic add_row(logic [1:0] cmd, logic signed [sis_pkg::KEY_W-1:0] key,
                         logic [31:0] payload,
                         bit fixed = 0, logic [1:0] status = sis_pkg::ST_DONE,
                         int count = 0, logic empty = 1'b0);
    stack_row_t row;
    row.cmd = cmd;
    row.key = key;
    row.payload = payload;
    row.fixed = fixed;
    row.result.key = '0;
    row.result.payload = '0;
    row.result.status = status;
    row.result.count = sis_pkg::CNT_W'(count);
    row.result.empty = empty;
    directed_rows.push_back(row);
  endtask

  // Drive one command and hold it until the block takes it; gap is idle cycles first.
  task automatic send_command(logic [1:0] cmd, logic signed [sis_pkg::KEY_W-1:0] key,
                              logic [31:0] payload, int gap, bit fixed,
                              stack_result_t fixed_result);
    stack_result_t predicted;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'd0, payload, key, cmd};
    do @(posedge clk_i); while (!s_axis_tready);
    predicted = apply_command(cmd, key, payload);
    pending_results.push_back(fixed ? fixed_result : predicted);
  endtask

  function automatic logic signed [sis_pkg::KEY_W-1:0] draw_key();
    logic signed [sis_pkg::KEY_W-1:0] k;
    case ($urandom_range(0, 5))
      0, 1: k = $urandom;
      2: k = $signed($urandom_range(0, 8)) - 4;   // crowd keys to force ties
      3: begin
        case ($urandom_range(0, 3))
          0: k = 32'sh8000_0000;
          1: k = 32'sh7fff_ffff;
          2: k = 0;
          default: k = -1;
        endcase
      end
      default: k = $urandom_range(0, 100);
    endcase
    return k;
  endfunction

  // result side: random stalls, check every transfer
  initial begin
    int stall;
    bit stall_on;
    int taken;
    stack_result_t got;
    stack_result_t want;
    m_axis_tready = 1'b0;
    stall_on = 1'b0;
    taken = 0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (taken % 32 == 0) stall_on = ($urandom_range(0, 2) != 0);
      stall = stall_on ? $urandom_range(0, 7) : 0;
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      taken++;
      got.key     = m_axis_tdata[31:0];
      got.payload = m_axis_tdata[63:32];
      got.status  = m_axis_tdata[65:64];
      got.count   = m_axis_tdata[70:66];
      got.empty   = m_axis_tdata[71];
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing pending", m_axis_tdata[31:0], '0);
      end else begin
        want = pending_results.pop_front();
        if (got.key !== want.key) report_mismatch("popped_key", got.key, want.key);
        if (got.payload !== want.payload)
          report_mismatch("popped_payload", got.payload, want.payload);
        if (got.status !== want.status) report_mismatch("status", got.status, want.status);
        if (got.count !== want.count) report_mismatch("entry_count", got.count, want.count);
        if (got.empty !== want.empty) report_mismatch("is_empty", got.empty, want.empty);
      end
    end
  end

  initial begin
    int gap;
    bit idle_on;
    int push_pct;
    int pick;
    logic [1:0] cmd;
    stack_result_t none;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    stack_fill = 0;
    mismatch_count = 0;
    none = '{default: '0};

    // an error case (pop) and an unused command code on an empty stack
    add_row(sis_pkg::CMD_POP, 0, 32'hffff_ffff, 1, sis_pkg::ST_EMPTY, 0, 1'b1);
    add_row(CMD_NOP, -1, 32'hffff_ffff, 1, sis_pkg::ST_DONE, 0, 1'b1);
    // ordered pushes: extremes, zero and negative keys, a tie; a plain push, a pop, a no-op
    add_row(sis_pkg::CMD_ORD_PUSH, 32'sh8000_0000, 32'hffff_ffff);
    add_row(sis_pkg::CMD_ORD_PUSH, 32'sh7fff_ffff, 32'h0000_0000);
    add_row(sis_pkg::CMD_ORD_PUSH, 0, 32'h5555_5555);
    add_row(sis_pkg::CMD_ORD_PUSH, -1, 32'haaaa_aaaa);
    add_row(sis_pkg::CMD_ORD_PUSH, 0, 32'h0000_0001);
    add_row(sis_pkg::CMD_PUSH, 5, 32'h8000_0000);
    add_row(sis_pkg::CMD_POP, 0, 0);
    add_row(CMD_NOP, 32'sh7fff_ffff, 0);
    // fill up to the top, push twice while full, then pop
    for (int i = 0; i < 11; i++)
      add_row((i % 2) ? sis_pkg::CMD_PUSH : sis_pkg::CMD_ORD_PUSH, (i * 37) - 200,
              32'h1000_0000 + i);
    add_row(sis_pkg::CMD_PUSH, 1, 1, 1, sis_pkg::ST_FULL, sis_pkg::DEPTH, 1'b0);
    add_row(sis_pkg::CMD_ORD_PUSH, 2, 2, 1, sis_pkg::ST_FULL, sis_pkg::DEPTH, 1'b0);
    add_row(sis_pkg::CMD_POP, 0, 0);

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    idle_on = 1'b0;
    foreach (directed_rows[i]) begin
      if (i % 8 == 0) idle_on = ($urandom_range(0, 1) != 0);
      gap = idle_on ? $urandom_range(0, 7) : 0;
      send_command(directed_rows[i].cmd, directed_rows[i].key, directed_rows[i].payload,
                   gap, directed_rows[i].fixed, directed_rows[i].result);
    end

    push_pct = 50;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      // change the push/pop mix now and then so the stack swings between full and empty
      if (n % 32 == 0) begin
        idle_on = ($urandom_range(0, 2) != 0);
        case ($urandom_range(0, 3))
          0: push_pct = 20;
          1: push_pct = 50;
          2: push_pct = 75;
          default: push_pct = 95;
        endcase
      end
      pick = $urandom_range(0, 99);
      if (pick < 2) cmd = CMD_NOP;
      else if (pick < 2 + push_pct)
        cmd = ($urandom_range(0, 9) < 6) ? sis_pkg::CMD_ORD_PUSH : sis_pkg::CMD_PUSH;
      else cmd = sis_pkg::CMD_POP;
      gap = idle_on ? $urandom_range(0, 7) : 0;
      send_command(cmd, draw_key(), $urandom, gap, 1'b0, none);
    end
    s_axis_tvalid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0)
      $display("PASS sorted_insert_stack_top");
    else
      $display("FAIL sorted_insert_stack_top");
    $finish;
  end

endmodule

### sim.f
rtl/sis_pkg.sv
rtl/sis_cell.sv
rtl/sorted_insert_stack_top.sv
test/sorted_insert_stack_top_test.sv
